// ----- rtl/ack_retry_command_queue_unit_macros.svh -----
// assertion macros for the command queue
`ifndef ACK_RETRY_COMMAND_QUEUE_UNIT_MACROS_SVH
`define ACK_RETRY_COMMAND_QUEUE_UNIT_MACROS_SVH
// assert that a condition implies a consequence at the same edge
`define ARCQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// assert that a condition implies a consequence at the following edge
`define ARCQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/arcq_pkg.sv -----
// shared types and codes of the command queue
package arcq_pkg;
	localparam int ENTRIES = 8;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_SET = 3'd1;
	localparam logic [2:0] OP_DISPATCH = 3'd2;
	localparam logic [2:0] OP_PAUSE = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;
	localparam logic [2:0] OP_POLL = 3'd5;

	localparam logic [2:0] ST_QUEUING = 3'd0;
	localparam logic [2:0] ST_WAITACK = 3'd1;
	localparam logic [2:0] ST_DELAYED = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_TOOMANY = 3'd4;
	localparam logic [2:0] ST_FAILED = 3'd5;
	localparam logic [2:0] ST_ABANDON = 3'd6;
	localparam logic [2:0] ST_PAUSED = 3'd7;

	localparam logic [2:0] RC_SUCCESS = 3'd0;
	localparam logic [2:0] RC_NONE = 3'd1;
	localparam logic [2:0] RC_BUSY = 3'd2;
	localparam logic [2:0] RC_PERIODIC = 3'd3;
	localparam logic [2:0] RC_NOTREMOVABLE = 3'd4;
	localparam logic [2:0] RC_FULL = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load;         // capture the incoming transaction
		logic append;       // write a new tail entry
		logic set_all;      // pause or resume, one slot per cycle while output is free
		logic visit;        // process slot at cursor (set, dispatch or poll)
		logic shift;        // move slot cursor+1 into cursor
		logic cursor_clr;
		logic cursor_inc;
		logic count_dec;
	} arcq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       at_end;     // cursor reached entry count
		logic       shift_end;  // cursor+1 reached entry count
		logic       id_hit;
		logic [2:0] cur_status; // status of slot at cursor before update
		logic [2:0] poll_status;// status after poll rules
		logic [2:0] cur_flags;
		logic [7:0] cur_id;
	} arcq_stat_t;
endpackage

// ----- rtl/ack_retry_command_queue_unit.sv -----
// top level of the acknowledge and retry command queue
// Holds up to ENTRIES commands in insertion order and runs one operation per
// input transaction: append, set status by id, dispatch, pause all, resume all
// or poll. The input channel (in_valid/in_stall) carries the command fields;
// the output channel (out_valid/out_stall) carries result transactions, the
// final one of each operation marked by last.
// A command is taken only when the previous one has delivered all results.
// Set status, dispatch, pause, resume and poll walk the table one slot per cycle
// while the output is not stalled. A poll that removes an entry moves the later
// entries up one slot per cycle. Reset empties the table; the entry storage itself
// is not cleared. While the receiver stalls, the held result stays on the output
// and the walk waits at its current slot.
`include "ack_retry_command_queue_unit_macros.svh"
module ack_retry_command_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  command_id,
	input  logic [2:0]  command_flags,
	input  logic [31:0] timeout_ticks,
	input  logic [7:0]  retry_limit,
	input  logic [2:0]  new_status,
	input  logic [31:0] time_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_code,
	output logic [7:0]  entry_id,
	output logic [2:0]  entry_status,
	output logic [2:0]  entry_flags,
	output logic        entry_valid,
	output logic        entry_removed,
	output logic        last
);
	arcq_pkg::arcq_cmd_t  cmd;
	arcq_pkg::arcq_stat_t stat;

	arcq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat,
		.result_code, .entry_id, .entry_status, .entry_flags, .entry_valid,
		.entry_removed, .last
	);

	arcq_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .opcode, .command_id, .command_flags,
		.timeout_ticks, .retry_limit, .new_status, .time_now
	);

	`ARCQ_ASSERT_IMP(a_no_accept_busy, in_valid && !in_stall, !out_valid || !out_stall)
	`ARCQ_ASSERT_IMP(a_removed_valid, out_valid && entry_removed, entry_valid && !last)
	`ARCQ_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_code))
endmodule

// ----- rtl/arcq_datapath.sv -----
// entry tables, slot cursor and per-slot update logic
module arcq_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  arcq_pkg::arcq_cmd_t     cmd,
	output arcq_pkg::arcq_stat_t    stat,
	input  logic [2:0]              opcode,
	input  logic [7:0]              command_id,
	input  logic [2:0]              command_flags,
	input  logic [31:0]             timeout_ticks,
	input  logic [7:0]              retry_limit,
	input  logic [2:0]              new_status,
	input  logic [31:0]             time_now
);
	logic [7:0]  id_q      [arcq_pkg::ENTRIES];
	logic [2:0]  flag_q    [arcq_pkg::ENTRIES];
	logic [31:0] tmo_q     [arcq_pkg::ENTRIES];
	logic [7:0]  lim_q     [arcq_pkg::ENTRIES];
	logic [7:0]  retry_q   [arcq_pkg::ENTRIES];
	logic [2:0]  status_q  [arcq_pkg::ENTRIES];
	logic [31:0] trig_q    [arcq_pkg::ENTRIES];

	logic [arcq_pkg::CNT_W-1:0] count_q;
	logic [arcq_pkg::CNT_W-1:0] cursor_q;
	logic [2:0]  op_q, nst_q, cfl_q;
	logic [7:0]  cid_q, lim_ld_q;
	logic [31:0] now_q, tmo_ld_q;

	logic [arcq_pkg::IDX_W-1:0] idx, nidx, tail;
	logic [31:0] elapsed;
	logic        expired;
	logic [7:0]  retry_inc;
	logic [2:0]  st_poll;
	logic [arcq_pkg::CNT_W-1:0] cursor_p1;

	assign cursor_p1 = cursor_q + 1'b1;
	assign idx = cursor_q[arcq_pkg::IDX_W-1:0];
	assign nidx = cursor_p1[arcq_pkg::IDX_W-1:0];
	assign tail = count_q[arcq_pkg::IDX_W-1:0];
	assign elapsed = now_q - trig_q[idx];
	assign expired = elapsed >= tmo_q[idx];
	assign retry_inc = (retry_q[idx] == 8'hFF) ? retry_q[idx] : retry_q[idx] + 8'd1;

	always_comb begin
		st_poll = status_q[idx];
		if (status_q[idx] == arcq_pkg::ST_DELAYED && expired)
			st_poll = arcq_pkg::ST_QUEUING;
		if (status_q[idx] == arcq_pkg::ST_WAITACK && expired) begin
			if (flag_q[idx][2] || lim_q[idx] >= retry_inc)
				st_poll = arcq_pkg::ST_QUEUING;
			else
				st_poll = arcq_pkg::ST_TOOMANY;
		end
	end

	assign stat.op = op_q;
	assign stat.full = count_q >= arcq_pkg::CNT_W'(arcq_pkg::ENTRIES);
	assign stat.at_end = cursor_q >= count_q;
	assign stat.shift_end = cursor_p1 >= count_q;
	assign stat.id_hit = id_q[idx] == cid_q;
	assign stat.cur_status = status_q[idx];
	assign stat.poll_status = st_poll;
	assign stat.cur_flags = flag_q[idx];
	assign stat.cur_id = id_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cursor_q <= '0;
			op_q <= arcq_pkg::OP_APPEND;
		end else begin
			if (cmd.load)
				op_q <= opcode;
			if (cmd.cursor_clr)
				cursor_q <= '0;
			else if (cmd.cursor_inc)
				cursor_q <= cursor_p1;
			if (cmd.append)
				count_q <= count_q + 1'b1;
			else if (cmd.count_dec)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cid_q <= command_id;
			nst_q <= new_status;
			now_q <= time_now;
			cfl_q <= command_flags;
			tmo_ld_q <= timeout_ticks;
			lim_ld_q <= retry_limit;
		end
		if (cmd.append) begin
			id_q[tail] <= cid_q;
			flag_q[tail] <= cfl_q;
			tmo_q[tail] <= tmo_ld_q;
			lim_q[tail] <= lim_ld_q;
			retry_q[tail] <= 8'd0;
			status_q[tail] <= arcq_pkg::ST_QUEUING;
			trig_q[tail] <= 32'd0;
		end
		if (cmd.set_all)
			status_q[idx] <= (op_q == arcq_pkg::OP_PAUSE) ? arcq_pkg::ST_PAUSED
				: arcq_pkg::ST_QUEUING;
		if (cmd.visit) begin
			unique case (op_q)
				arcq_pkg::OP_SET: begin
					status_q[idx] <= nst_q;
					retry_q[idx] <= 8'd0;
				end
				arcq_pkg::OP_DISPATCH: begin
					status_q[idx] <= flag_q[idx][0] ? arcq_pkg::ST_WAITACK
						: flag_q[idx][1] ? arcq_pkg::ST_DELAYED : arcq_pkg::ST_FINISHED;
					trig_q[idx] <= now_q;
				end
				default: begin
					status_q[idx] <= st_poll;
					if (status_q[idx] == arcq_pkg::ST_WAITACK && expired)
						retry_q[idx] <= retry_inc;
				end
			endcase
		end
		if (cmd.shift) begin
			id_q[idx] <= id_q[nidx];
			flag_q[idx] <= flag_q[nidx];
			tmo_q[idx] <= tmo_q[nidx];
			lim_q[idx] <= lim_q[nidx];
			retry_q[idx] <= retry_q[nidx];
			status_q[idx] <= status_q[nidx];
			trig_q[idx] <= trig_q[nidx];
		end
	end
endmodule

// ----- rtl/arcq_ctrl.sv -----
// sequencer for the command queue operations and result output register
module arcq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output arcq_pkg::arcq_cmd_t     cmd,
	input  arcq_pkg::arcq_stat_t    stat,
	output logic [2:0]              result_code,
	output logic [7:0]              entry_id,
	output logic [2:0]              entry_status,
	output logic [2:0]              entry_flags,
	output logic                    entry_valid,
	output logic                    entry_removed,
	output logic                    last
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_WALK, S_SHIFT, S_SUMMARY, S_OUT
	} state_t;

	state_t     state_q, ret_q;
	logic [2:0] code_q;
	logic       out_free, ld;
	logic [2:0] ncode;
	logic       rem;
	logic       fin;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = state_q != S_IDLE;
	assign ld = in_valid && state_q == S_IDLE;
	assign fin = stat.poll_status == arcq_pkg::ST_FINISHED ||
		stat.poll_status == arcq_pkg::ST_TOOMANY ||
		stat.poll_status == arcq_pkg::ST_FAILED ||
		stat.poll_status == arcq_pkg::ST_ABANDON;
	assign rem = fin && !stat.cur_flags[1];
	assign ncode = !fin ? arcq_pkg::RC_NOTREMOVABLE
		: rem ? arcq_pkg::RC_SUCCESS : arcq_pkg::RC_PERIODIC;

	always_comb begin
		cmd = '0;
		cmd.load = ld;
		cmd.cursor_clr = ld;
		unique case (state_q)
			S_DECODE: begin
				cmd.append = stat.op == arcq_pkg::OP_APPEND && !stat.full;
			end
			S_WALK: begin
				if (!stat.at_end && out_free) begin
					unique case (stat.op)
						arcq_pkg::OP_PAUSE, arcq_pkg::OP_RESUME: begin
							cmd.set_all = 1'b1;
							cmd.cursor_inc = 1'b1;
						end
						arcq_pkg::OP_SET: begin
							cmd.visit = stat.id_hit;
							cmd.cursor_inc = !stat.id_hit;
						end
						arcq_pkg::OP_DISPATCH: begin
							cmd.visit = stat.cur_status == arcq_pkg::ST_QUEUING;
							cmd.cursor_inc = stat.cur_status != arcq_pkg::ST_QUEUING &&
								stat.cur_status != arcq_pkg::ST_WAITACK;
						end
						default: begin
							if (stat.cur_status == arcq_pkg::ST_PAUSED)
								cmd.cursor_inc = 1'b1;
							else begin
								cmd.visit = 1'b1;
								cmd.cursor_inc = !rem;
							end
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (stat.shift_end)
					cmd.count_dec = 1'b1;
				else begin
					cmd.shift = 1'b1;
					cmd.cursor_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			out_valid <= 1'b0;
			code_q <= arcq_pkg::RC_NONE;
			result_code <= arcq_pkg::RC_NONE;
			entry_id <= '0;
			entry_status <= '0;
			entry_flags <= '0;
			entry_valid <= 1'b0;
			entry_removed <= 1'b0;
			last <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
						code_q <= arcq_pkg::RC_NONE;
					end
				end
				S_DECODE: begin
					if (stat.op == arcq_pkg::OP_APPEND) begin
						code_q <= stat.full ? arcq_pkg::RC_FULL : arcq_pkg::RC_SUCCESS;
						state_q <= S_SUMMARY;
					end else if (stat.op == arcq_pkg::OP_PAUSE ||
						stat.op == arcq_pkg::OP_RESUME) begin
						code_q <= arcq_pkg::RC_SUCCESS;
						state_q <= S_WALK;
					end else if (stat.op == arcq_pkg::OP_SET ||
						stat.op == arcq_pkg::OP_DISPATCH ||
						stat.op == arcq_pkg::OP_POLL) begin
						state_q <= S_WALK;
					end else
						state_q <= S_SUMMARY;
				end
				S_WALK: begin
					if (stat.at_end)
						state_q <= S_SUMMARY;
					else if (out_free) begin
						unique case (stat.op)
							arcq_pkg::OP_SET: begin
								if (stat.id_hit) begin
									code_q <= arcq_pkg::RC_SUCCESS;
									state_q <= S_SUMMARY;
								end
							end
							arcq_pkg::OP_DISPATCH: begin
								if (stat.cur_status == arcq_pkg::ST_WAITACK) begin
									code_q <= arcq_pkg::RC_BUSY;
									state_q <= S_SUMMARY;
								end else if (stat.cur_status == arcq_pkg::ST_QUEUING) begin
									out_valid <= 1'b1;
									result_code <= arcq_pkg::RC_BUSY;
									entry_id <= stat.cur_id;
									entry_status <= stat.cur_flags[0] ? arcq_pkg::ST_WAITACK
										: stat.cur_flags[1] ? arcq_pkg::ST_DELAYED
										: arcq_pkg::ST_FINISHED;
									entry_flags <= stat.cur_flags;
									entry_valid <= 1'b1;
									entry_removed <= 1'b0;
									last <= 1'b1;
									state_q <= S_OUT;
									ret_q <= S_IDLE;
								end
							end
							arcq_pkg::OP_POLL: begin
								if (stat.cur_status != arcq_pkg::ST_PAUSED) begin
									code_q <= ncode;
									out_valid <= 1'b1;
									result_code <= ncode;
									entry_id <= stat.cur_id;
									entry_status <= stat.poll_status;
									entry_flags <= stat.cur_flags;
									entry_valid <= 1'b1;
									entry_removed <= rem;
									last <= 1'b0;
									if (rem)
										state_q <= S_SHIFT;
								end
							end
							default: ;
						endcase
					end
				end
				S_SHIFT: begin
					if (stat.shift_end)
						state_q <= S_SUMMARY;
				end
				S_SUMMARY: begin
					if (out_free) begin
						out_valid <= 1'b1;
						result_code <= code_q;
						entry_id <= '0;
						entry_status <= '0;
						entry_flags <= '0;
						entry_valid <= 1'b0;
						entry_removed <= 1'b0;
						last <= 1'b1;
						state_q <= S_OUT;
						ret_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free || !out_valid)
						state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sim/ack_retry_command_queue_unit_tb.sv -----
// testbench for the ack and retry command queue: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module ack_retry_command_queue_unit_tb;
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  cid;
		logic [2:0]  cflags;
		logic [31:0] tmo;
		logic [7:0]  lim;
		logic [2:0]  nst;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] id;
		logic [2:0] status;
		logic [2:0] flags;
		logic       valid;
		logic       removed;
		logic       last;
	} res_t;

	localparam logic [2:0] FL_WAITACK = 3'd1;
	localparam logic [2:0] FL_PERIODIC = 3'd2;
	localparam logic [2:0] FL_MUSTOK = 3'd4;

	// opcodes with no operation behind them
	localparam logic [2:0] OP_UNUSED_A = 3'd6;
	localparam logic [2:0] OP_UNUSED_B = 3'd7;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] opcode, command_flags, new_status;
	logic [7:0] command_id, retry_limit;
	logic [31:0] timeout_ticks, time_now;
	logic [2:0] result_code, entry_status, entry_flags;
	logic [7:0] entry_id;
	logic entry_valid, entry_removed, last;

	ack_retry_command_queue_unit u_top (.*);

	// model of the command table
	int unsigned q_count;
	logic [7:0]  q_id [arcq_pkg::ENTRIES];
	logic [2:0]  q_flags [arcq_pkg::ENTRIES];
	logic [31:0] q_tmo [arcq_pkg::ENTRIES];
	logic [7:0]  q_lim [arcq_pkg::ENTRIES];
	logic [7:0]  q_retry [arcq_pkg::ENTRIES];
	logic [2:0]  q_status [arcq_pkg::ENTRIES];
	logic [31:0] q_trig [arcq_pkg::ENTRIES];

	res_t expected_results[$];
	int errors = 0;
	bit rx_hold = 0, quiet = 0;

	function automatic res_t mk(logic [2:0] code, int s, bit v, bit rm, bit lst);
		res_t r;
		r = '0;
		r.code = code;
		r.valid = v;
		r.removed = rm;
		r.last = lst;
		if (v) begin
			r.id = q_id[s];
			r.status = q_status[s];
			r.flags = q_flags[s];
		end
		return r;
	endfunction

	task automatic drop_slot(int s);
		for (int j = s; j + 1 < q_count; j++) begin
			q_id[j] = q_id[j+1]; q_flags[j] = q_flags[j+1]; q_tmo[j] = q_tmo[j+1];
			q_lim[j] = q_lim[j+1]; q_retry[j] = q_retry[j+1];
			q_status[j] = q_status[j+1]; q_trig[j] = q_trig[j+1];
		end
		q_count--;
	endtask

	task automatic predict_command(cmd_t c);
		logic [2:0] code, st;
		logic [31:0] elapsed;
		bit done;
		done = 0;
		case (c.op)
			arcq_pkg::OP_APPEND: begin
				if (q_count >= arcq_pkg::ENTRIES)
					expected_results.push_back(mk(arcq_pkg::RC_FULL, 0, 0, 0, 1));
				else begin
					q_id[q_count] = c.cid; q_flags[q_count] = c.cflags;
					q_tmo[q_count] = c.tmo; q_lim[q_count] = c.lim;
					q_retry[q_count] = 0; q_status[q_count] = arcq_pkg::ST_QUEUING;
					q_trig[q_count] = 0;
					q_count++;
					expected_results.push_back(mk(arcq_pkg::RC_SUCCESS, 0, 0, 0, 1));
				end
			end
			arcq_pkg::OP_SET: begin
				for (int i = 0; i < q_count && !done; i++)
					if (q_id[i] == c.cid) begin
						q_status[i] = c.nst;
						q_retry[i] = 0;
						done = 1;
					end
				expected_results.push_back(mk(done ? arcq_pkg::RC_SUCCESS : arcq_pkg::RC_NONE,
					0, 0, 0, 1));
			end
			arcq_pkg::OP_DISPATCH: begin
				for (int i = 0; i < q_count && !done; i++) begin
					if (q_status[i] == arcq_pkg::ST_WAITACK) begin
						expected_results.push_back(mk(arcq_pkg::RC_BUSY, 0, 0, 0, 1));
						done = 1;
					end else if (q_status[i] == arcq_pkg::ST_QUEUING) begin
						if (q_flags[i] & FL_WAITACK) q_status[i] = arcq_pkg::ST_WAITACK;
						else if (q_flags[i] & FL_PERIODIC) q_status[i] = arcq_pkg::ST_DELAYED;
						else q_status[i] = arcq_pkg::ST_FINISHED;
						q_trig[i] = c.now;
						expected_results.push_back(mk(arcq_pkg::RC_BUSY, i, 1, 0, 1));
						done = 1;
					end
				end
				if (!done) expected_results.push_back(mk(arcq_pkg::RC_NONE, 0, 0, 0, 1));
			end
			arcq_pkg::OP_PAUSE, arcq_pkg::OP_RESUME: begin
				for (int i = 0; i < q_count; i++)
					q_status[i] = (c.op == arcq_pkg::OP_PAUSE) ? arcq_pkg::ST_PAUSED
						: arcq_pkg::ST_QUEUING;
				expected_results.push_back(mk(arcq_pkg::RC_SUCCESS, 0, 0, 0, 1));
			end
			arcq_pkg::OP_POLL: begin
				code = arcq_pkg::RC_NONE;
				for (int i = 0; i < q_count && !done; i++) begin
					st = q_status[i];
					if (st != arcq_pkg::ST_PAUSED) begin
						elapsed = c.now - q_trig[i];
						if (st == arcq_pkg::ST_DELAYED && elapsed >= q_tmo[i])
							st = arcq_pkg::ST_QUEUING;
						if (st == arcq_pkg::ST_WAITACK && elapsed >= q_tmo[i]) begin
							if (q_retry[i] != 8'hff) q_retry[i]++;
							st = ((q_flags[i] & FL_MUSTOK) || q_lim[i] >= q_retry[i]) ?
								arcq_pkg::ST_QUEUING : arcq_pkg::ST_TOOMANY;
						end
						q_status[i] = st;
						if (st inside {arcq_pkg::ST_FINISHED, arcq_pkg::ST_TOOMANY,
							arcq_pkg::ST_FAILED, arcq_pkg::ST_ABANDON}) begin
							if (q_flags[i] & FL_PERIODIC) begin
								code = arcq_pkg::RC_PERIODIC;
								expected_results.push_back(mk(code, i, 1, 0, 0));
							end else begin
								code = arcq_pkg::RC_SUCCESS;
								expected_results.push_back(mk(code, i, 1, 1, 0));
								drop_slot(i);
								done = 1;
							end
						end else begin
							code = arcq_pkg::RC_NOTREMOVABLE;
							expected_results.push_back(mk(code, i, 1, 0, 0));
						end
					end
				end
				expected_results.push_back(mk(code, 0, 0, 0, 1));
			end
			default: expected_results.push_back(mk(arcq_pkg::RC_NONE, 0, 0, 0, 1));
		endcase
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("** ack_retry_command_queue_unit: FAILED **");
		$finish;
	end

	// result checking
	always @(posedge clk) begin
		res_t got, exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_code, entry_id, entry_status, entry_flags,
				entry_valid, entry_removed, last};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
					errors++;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 0;
		else out_stall <= rx_hold || (!quiet && $urandom_range(99) < 30);
	end

	cmd_t dir_cmds[$];
	res_t dir_exp[$];
	bit dir_has_exp[$];

	function automatic cmd_t c_mk(logic [2:0] op, logic [7:0] id, logic [2:0] fl,
			logic [31:0] tmo, logic [7:0] lim, logic [2:0] ns, logic [31:0] now);
		cmd_t c;
		c = '{op, id, fl, tmo, lim, ns, now};
		return c;
	endfunction

	function automatic cmd_t rand_cmd(logic [31:0] clock_now);
		cmd_t c;
		int r;
		logic [2:0] ops[4];
		c.cid = 8'($urandom_range(7)) | (($urandom_range(3) == 0) ? 8'($urandom) : 8'h0);
		c.cflags = 3'($urandom_range(7));
		r = $urandom_range(9);
		c.tmo = (r == 0) ? $urandom : (r == 1) ? 32'hffffffff : $urandom_range(40);
		c.lim = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		c.nst = 3'($urandom_range(7));
		c.now = ($urandom_range(15) == 0) ? $urandom : clock_now;
		r = $urandom_range(99);
		ops[0] = arcq_pkg::OP_PAUSE; ops[1] = arcq_pkg::OP_RESUME;
		ops[2] = OP_UNUSED_A; ops[3] = OP_UNUSED_B;
		if (r < 25) c.op = arcq_pkg::OP_APPEND;
		else if (r < 40) c.op = arcq_pkg::OP_SET;
		else if (r < 62) c.op = arcq_pkg::OP_DISPATCH;
		else if (r < 92) c.op = arcq_pkg::OP_POLL;
		else c.op = ops[$urandom_range(3)];
		return c;
	endfunction

	// valid stays high after acceptance until the next idle cycle or command
	task automatic send(input cmd_t c, output int first_idx);
		while (!quiet && $urandom_range(99) < 30) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{opcode, command_id, command_flags, timeout_ticks, retry_limit, new_status,
			time_now} <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		first_idx = expected_results.size();
		predict_command(c);
	endtask

	initial begin
		int n_exp;
		logic [31:0] clock_now;
		res_t first_exp;
		in_valid = 0;
		{opcode, command_id, command_flags, timeout_ticks, retry_limit, new_status,
			time_now} = '0;
		q_count = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty-table codes, fill to full, dispatch kinds, timeouts, poll removal
		dir_cmds.push_back(c_mk(arcq_pkg::OP_POLL, 0, 0, 0, 0, 0, 0));
		dir_exp.push_back(mk(arcq_pkg::RC_NONE, 0, 0, 0, 1)); dir_has_exp.push_back(1);
		dir_cmds.push_back(c_mk(arcq_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0));
		dir_exp.push_back(mk(arcq_pkg::RC_NONE, 0, 0, 0, 1)); dir_has_exp.push_back(1);
		dir_cmds.push_back(c_mk(arcq_pkg::OP_SET, 8'hff, 0, 0, 0, arcq_pkg::ST_PAUSED, 0));
		dir_exp.push_back(mk(arcq_pkg::RC_NONE, 0, 0, 0, 1)); dir_has_exp.push_back(1);
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h00, 3'd1, 32'd5, 8'd0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'hff, 3'd2, 32'hffffffff, 8'hff, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h55, 3'd0, 0, 0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'haa, 3'd7, 32'd1, 8'd2, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h55, 3'd4, 32'd3, 8'd1, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h01, 3'd3, 0, 0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h02, 3'd5, 32'd2, 8'd0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h03, 3'd6, 32'd0, 8'd0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_APPEND, 8'h04, 3'd0, 0, 0, 0, 0));
		for (int i = 3; i < 12; i++) begin
			dir_exp.push_back(mk(i == 11 ? arcq_pkg::RC_FULL : arcq_pkg::RC_SUCCESS,
				0, 0, 0, 1));
			dir_has_exp.push_back(1);
		end
		dir_cmds.push_back(c_mk(arcq_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 32'hfffffffe));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 32'd1));
		dir_exp.push_back(mk(arcq_pkg::RC_BUSY, 0, 0, 0, 1)); dir_has_exp.push_back(0);
		dir_exp.push_back(mk(arcq_pkg::RC_BUSY, 0, 0, 0, 1)); dir_has_exp.push_back(1);
		dir_cmds.push_back(c_mk(arcq_pkg::OP_POLL, 0, 0, 0, 0, 0, 32'd3));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_POLL, 0, 0, 0, 0, 0, 32'd10));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_SET, 8'h55, 0, 0, 0, arcq_pkg::ST_FAILED, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_SET, 8'haa, 0, 0, 0, arcq_pkg::ST_ABANDON, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_PAUSE, 0, 0, 0, 0, 0, 0));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_POLL, 0, 0, 0, 0, 0, 32'd20));
		dir_cmds.push_back(c_mk(arcq_pkg::OP_RESUME, 0, 0, 0, 0, 0, 0));
		dir_cmds.push_back(c_mk(OP_UNUSED_A, 0, 0, 0, 0, 0, 0));
		dir_cmds.push_back(c_mk(OP_UNUSED_B, 0, 0, 0, 0, 0, 0));
		for (int i = 14; i < dir_cmds.size(); i++) begin
			dir_exp.push_back('0);
			dir_has_exp.push_back(0);
		end
		foreach (dir_cmds[i]) begin
			send(dir_cmds[i], n_exp);
			first_exp = expected_results[n_exp];
			if (dir_has_exp[i] && first_exp !== dir_exp[i]) begin
				$display("%0t: table row %0d expected %h actual prediction %h",
					$time, i, dir_exp[i], first_exp);
				errors++;
			end
		end

		// random traffic with time moving forward
		clock_now = 32'hffffff00;
		for (int k = 0; k < 250; k++) begin
			if (k == 60) begin
				// sender pauses until every result has arrived
				in_valid <= 0;
				while (expected_results.size() != 0) @(posedge clk);
			end
			if (k == 100) begin
				fork
					begin
						rx_hold = 1;
						repeat (200) @(posedge clk);
						rx_hold = 0;
					end
				join_none
			end
			quiet = (k >= 150 && k < 190);
			clock_now += $urandom_range(6);
			send(rand_cmd(clock_now), n_exp);
		end
		quiet = 0;
		in_valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("** ack_retry_command_queue_unit: PASSED **");
		else
			$display("** ack_retry_command_queue_unit: FAILED **");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/arcq_pkg.sv
rtl/arcq_datapath.sv
rtl/arcq_ctrl.sv
rtl/ack_retry_command_queue_unit.sv
sim/ack_retry_command_queue_unit_tb.sv
